@@ design/slfs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slfs_pkg: shared types and constants for the frame scanner
// Sync bytes, header size, scan phases and the result record.
// ----------------------------------------------------------------------------
package slfs_pkg;

    localparam int OFFSET_BITS     = 48;
    localparam int OUT_OFFSET_BITS = 48;
    localparam int OUT_LENGTH_BITS = 17;

    localparam logic [7:0]  SYNC_FIRST   = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND  = 8'hBB;
    localparam logic [15:0] STAMP_BYTES  = 16'd4;
    localparam logic [16:0] HEADER_BYTES = 17'd8;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    typedef enum logic [3:0] {
        PH_HUNT   = 4'd0,
        PH_SYNC2  = 4'd1,
        PH_LEN_LO = 4'd2,
        PH_LEN_HI = 4'd3,
        PH_STAMP  = 4'd4,
        PH_BODY   = 4'd5
    } scan_phase_t;

    typedef struct packed {
        logic [OUT_OFFSET_BITS-1:0] frame_offset;
        logic [OUT_LENGTH_BITS-1:0] frame_length;
    } frame_result_t;

endpackage : slfs_pkg
`default_nettype wire

@@ design/sync_length_frame_scanner_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sync_length_frame_scanner_top: sync-word, length-prefixed frame scanner
// Scans a byte stream and reports the offset and size of each whole frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready/s_data_byte) carries one stream byte per
//   request. Output channel (m_valid/m_ready/m_frame_offset/m_frame_length)
//   carries one report per complete frame: offset of the first sync byte
//   (0xAA) and total size (payload length plus eight).
//   A byte is first held in the input register, then the scan core updates
//   its state and, on the last byte of a frame, loads the result register.
//   m_valid is driven from the result register, so a report passes the input
//   register and then the result register before the receiver can take it.
//   Throughput is one byte per cycle while no report is stalled, set by the
//   update of the scan state machine between the input and result registers.
//   When the receiver stalls with a report pending, the core holds every
//   byte in the input register, whether it closes a frame or not; one more
//   byte may be accepted if that register is empty, then s_ready drops.
//   The stream offset saturates at its top value.
//   Reset (aresetn low, synchronous) drops any held byte and report and
//   returns the scanner to hunting for a sync byte at offset zero.
// ----------------------------------------------------------------------------
module sync_length_frame_scanner_top
    import slfs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [7:0]            s_data_byte,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [OUT_OFFSET_BITS-1:0] m_frame_offset,
    output logic [OUT_LENGTH_BITS-1:0] m_frame_length
);

    logic          byte_valid;
    logic [7:0]    byte_data;
    logic          out_free;
    logic          step;
    logic          done;
    frame_result_t result;

    // advance the core only when a report it may produce has a place to go
    assign step = byte_valid && out_free;

    slfs_in_reg u_in_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .consume     (step),
        .byte_valid  (byte_valid),
        .byte_data   (byte_data)
    );

    slfs_scan_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .data_byte (byte_data),
        .done      (done),
        .result    (result)
    );

    slfs_out_reg u_out_reg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (step && done),
        .result         (result),
        .free           (out_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_offset (m_frame_offset),
        .m_frame_length (m_frame_length)
    );

endmodule : sync_length_frame_scanner_top
`default_nettype wire

@@ design/slfs_in_reg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slfs_in_reg: input byte register
// Holds one accepted byte until the scan core consumes it.
// ----------------------------------------------------------------------------
module slfs_in_reg
    import slfs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       consume,
    output logic            byte_valid,
    output logic [7:0]      byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // accept when empty or when the held byte leaves this cycle
    assign s_ready    = !valid_reg || consume;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !consume);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule : slfs_in_reg
`default_nettype wire

@@ design/slfs_scan_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slfs_scan_core: frame hunt and skip state machine
// Tracks the stream offset and the frame header; flags the last frame byte.
// ----------------------------------------------------------------------------
module slfs_scan_core
    import slfs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic [7:0] data_byte,
    output logic            done,
    output frame_result_t   result
);

    scan_phase_t            phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] byte_offset_reg, byte_offset_next;
    logic [OFFSET_BITS-1:0] start_offset_reg, start_offset_next;
    logic [15:0]            payload_length_reg, payload_length_next;
    logic [15:0]            bytes_left_reg, bytes_left_next;
    logic [15:0]            left_dec;

    assign left_dec = bytes_left_reg - 16'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_HUNT;
            byte_offset_reg    <= '0;
            start_offset_reg   <= '0;
            payload_length_reg <= '0;
            bytes_left_reg     <= '0;
        end else if (step) begin
            phase_reg          <= phase_next;
            byte_offset_reg    <= byte_offset_next;
            start_offset_reg   <= start_offset_next;
            payload_length_reg <= payload_length_next;
            bytes_left_reg     <= bytes_left_next;
        end
    end

    always_comb begin
        phase_next          = phase_reg;
        start_offset_next   = start_offset_reg;
        payload_length_next = payload_length_reg;
        bytes_left_next     = bytes_left_reg;
        done                = 1'b0;

        unique case (phase_reg)
            PH_SYNC2: begin
                if (data_byte == SYNC_SECOND) begin
                    phase_next = PH_LEN_LO;
                end else if (data_byte == SYNC_FIRST) begin
                    start_offset_next = byte_offset_reg;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
            PH_LEN_LO: begin
                payload_length_next = {8'd0, data_byte};
                phase_next          = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                payload_length_next = {data_byte, payload_length_reg[7:0]};
                bytes_left_next     = STAMP_BYTES;
                phase_next          = PH_STAMP;
            end
            PH_STAMP: begin
                bytes_left_next = left_dec;
                if (left_dec == 16'd0) begin
                    if (payload_length_reg == 16'd0) begin
                        done       = 1'b1;
                        phase_next = PH_HUNT;
                    end else begin
                        bytes_left_next = payload_length_reg;
                        phase_next      = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                bytes_left_next = left_dec;
                if (left_dec == 16'd0) begin
                    done       = 1'b1;
                    phase_next = PH_HUNT;
                end
            end
            default: begin
                // hunting, and any unused phase code
                if (data_byte == SYNC_FIRST) begin
                    start_offset_next = byte_offset_reg;
                    phase_next        = PH_SYNC2;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
    end

    // saturate at the top offset
    assign byte_offset_next = (byte_offset_reg != OFFSET_MAX)
                              ? byte_offset_reg + OFFSET_BITS'(1)
                              : byte_offset_reg;

    assign result.frame_offset = OUT_OFFSET_BITS'(start_offset_reg);
    assign result.frame_length = {1'b0, payload_length_reg} + HEADER_BYTES;

endmodule : slfs_scan_core
`default_nettype wire

@@ design/slfs_out_reg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slfs_out_reg: result register
// Holds one frame report until the receiver takes it.
// ----------------------------------------------------------------------------
module slfs_out_reg
    import slfs_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        load,
    input  wire frame_result_t               result,
    output logic                             free,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [OUT_OFFSET_BITS-1:0]       m_frame_offset,
    output logic [OUT_LENGTH_BITS-1:0]       m_frame_length
);

    logic          valid_reg;
    logic          valid_next;
    frame_result_t result_reg;

    assign free       = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid        = valid_reg;
    assign m_frame_offset = result_reg.frame_offset;
    assign m_frame_length = result_reg.frame_length;

endmodule : slfs_out_reg
`default_nettype wire
